// ===== rtl/rpcc_pkg.sv =====
// shared types, constants and crc function for the radio packet crc check
package rpcc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'h1D0F;
    localparam int          NSTG     = 6;
    localparam int          CHK1_STG = 2;

    typedef struct packed {
        logic [7:0] pkt_byte0;
        logic [7:0] pkt_byte1;
        logic [7:0] pkt_byte2;
        logic [7:0] pkt_byte3;
        logic [7:0] pkt_byte4;
        logic [7:0] pkt_byte5;
        logic [7:0] pkt_byte6;
    } t_pkt_in;

    typedef struct packed {
        logic       packet_ok;
        logic [7:0] ident_first;
        logic [7:0] ident_second;
        logic [3:0] key_code;
        logic [2:0] kind_code;
        logic [2:0] class_code;
        logic [7:0] extra_byte;
    } t_pkt_out;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] get_byte(input t_pkt_in p, input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = p.pkt_byte0;
            1:       b = p.pkt_byte1;
            2:       b = p.pkt_byte2;
            3:       b = p.pkt_byte3;
            4:       b = p.pkt_byte4;
            5:       b = p.pkt_byte5;
            default: b = p.pkt_byte6;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/radio_packet_crc_check_decode_core.sv =====
// Checks both CRC fields (poly 0x1021, seed 0x1D0F) of a seven-byte radio packet, a
// CRC-16 in bytes 3-4 and the low CRC byte in byte 6, and decodes its fields; one item is
// taken per cycle while o_stall is low: six register stages each fold one packet byte into
// the CRC, then an output register holds the result. A stalled output only holds the
// stages behind it that are full, so empty stages keep taking items.
module radio_packet_crc_check_decode_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rpcc_pkg::t_pkt_in  i_pkt,
    output logic               o_valid,
    input  logic               i_stall,
    output rpcc_pkg::t_pkt_out o_res
);
    import rpcc_pkg::*;

    logic [NSTG-1:0] r_v;
    t_pkt_in         r_pkt [NSTG];
    logic [15:0]     r_crc [NSTG];
    logic [NSTG-1:0] r_ok1;
    logic [15:0]     n_crc [NSTG];
    logic [NSTG-1:0] mv;
    logic            mv_out;
    logic            r_ov;
    t_pkt_out        r_res;
    t_pkt_out        dec_res;

    // advance chain, a stage moves when it is empty or the next one moves
    always_comb begin
        mv_out     = !r_ov || !i_stall;
        mv[NSTG-1] = !r_v[NSTG-1] || mv_out;
        for (int k = NSTG - 2; k >= 0; k--) begin
            mv[k] = !r_v[k] || mv[k+1];
        end
    end

    always_comb begin
        n_crc[0] = crc_byte(CRC_SEED, i_pkt.pkt_byte0);
        for (int k = 1; k < NSTG; k++) begin
            n_crc[k] = crc_byte(r_crc[k-1], get_byte(r_pkt[k-1], k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (mv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (mv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (mv_out) begin
                r_ov <= r_v[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[0] && i_valid) begin
            r_pkt[0] <= i_pkt;
            r_crc[0] <= n_crc[0];
            r_ok1[0] <= 1'b0;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (mv[k] && r_v[k-1]) begin
                r_pkt[k] <= r_pkt[k-1];
                r_crc[k] <= n_crc[k];
                if (k == CHK1_STG) begin
                    r_ok1[k] <= (n_crc[k] == {r_pkt[k-1].pkt_byte3, r_pkt[k-1].pkt_byte4});
                end else begin
                    r_ok1[k] <= r_ok1[k-1];
                end
            end
        end
        if (mv_out && r_v[NSTG-1]) begin
            r_res <= dec_res;
        end
    end

    rpcc_decode u_decode (
        .i_pkt (r_pkt[NSTG-1]),
        .i_crc (r_crc[NSTG-1]),
        .i_ok1 (r_ok1[NSTG-1]),
        .o_res (dec_res)
    );

    assign o_stall = !mv[0];
    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

// ===== rtl/rpcc_decode.sv =====
// final crc compare and field decode of one packet
module rpcc_decode (
    input  rpcc_pkg::t_pkt_in  i_pkt,
    input  logic [15:0]        i_crc,
    input  logic               i_ok1,
    output rpcc_pkg::t_pkt_out o_res
);
    import rpcc_pkg::*;

    logic ok;

    assign ok = i_ok1 && (i_crc[7:0] == i_pkt.pkt_byte6);

    always_comb begin
        o_res = '0;
        if (ok) begin
            o_res.packet_ok    = 1'b1;
            o_res.ident_first  = i_pkt.pkt_byte0;
            o_res.ident_second = i_pkt.pkt_byte1;
            o_res.key_code     = i_pkt.pkt_byte5[3:0];
            o_res.kind_code    = {i_pkt.pkt_byte5[5:4], 1'b0};
            o_res.class_code   = {1'b0, i_pkt.pkt_byte5[7:6]} + 3'd1;
            o_res.extra_byte   = i_pkt.pkt_byte2;
        end
    end

endmodule

// ===== rtl/rpcc_checker.sv =====
// port-level assertions for the radio packet crc check core, with bind
module rpcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input rpcc_pkg::t_pkt_in  i_pkt,
    input logic               o_valid,
    input logic               i_stall,
    input rpcc_pkg::t_pkt_out o_res
);
    import rpcc_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_pkt))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result item changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.packet_ok |-> o_res == '0)
        else $error("failed item has nonzero fields");

    a_pass_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.packet_ok |-> o_res.class_code != 3'd0 && !o_res.kind_code[0])
        else $error("passed item has bad class or kind code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("core not idle after reset");

endmodule

bind radio_packet_crc_check_decode_core rpcc_checker u_rpcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_pkt   (i_pkt),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
